[design/slas_pkg.sv]
// ----------------------------------------------------------------------------
// slas_pkg
// Types, register codes and repeat-stage tables shared by the slider
// autorepeat stepper.
// ----------------------------------------------------------------------------
package slas_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_DELAY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE_STEP   = 1'd1;
   localparam int unsigned CSR_DATA_W = 7;

   localparam logic [3:0] RESET_INITIAL_DELAY = 4'd9;
   localparam logic [6:0] RESET_COARSE_STEP   = 7'd10;

   // Direction bit positions in the tracked button set
   localparam int unsigned DIR_LEFT  = 0;
   localparam int unsigned DIR_RIGHT = 1;
   localparam int unsigned DIR_LSH   = 2;
   localparam int unsigned DIR_RSH   = 3;

   localparam logic [7:0] REPEAT_MAX = 8'd255;

   // Repeat stages: threshold on repeat count, interval, multiplier
   localparam logic [7:0] STAGE_THRESHOLD [4] = '{8'd0, 8'd6, 8'd14, 8'd26};
   localparam logic [3:0] STAGE_INTERVAL  [4] = '{4'd4, 4'd3, 4'd2, 4'd2};
   localparam logic [6:0] STAGE_MULT      [4] = '{7'd1, 7'd1, 7'd2, 7'd4};

   typedef struct packed {
      logic confirm;
      logic left;
      logic right;
      logic lshoulder;
      logic rshoulder;
   } btn_type;

   typedef struct packed {
      logic [3:0] dirs;
      logic [3:0] delay_left;
      logic [7:0] repeat_count;
   } rep_state_type;

   function automatic logic [1:0] stage_of(input logic [7:0] count);
      logic [1:0] s;
      if (count >= STAGE_THRESHOLD[3]) begin
         s = 2'd3;
      end else if (count >= STAGE_THRESHOLD[2]) begin
         s = 2'd2;
      end else if (count >= STAGE_THRESHOLD[1]) begin
         s = 2'd1;
      end else begin
         s = 2'd0;
      end
      return s;
   endfunction

endpackage

[design/slas_repeat_ctrl.sv]
// ----------------------------------------------------------------------------
// slas_repeat_ctrl
// Press tracking and accelerating repeat: next tracker state and signed step
// for one tick.
// ----------------------------------------------------------------------------
module slas_repeat_ctrl
   import slas_pkg::*;
#(
   parameter int ID_BITS = 32
) (
   input  logic [ID_BITS-1:0] id,
   input  logic               focused,
   input  logic               text_entry_active,
   input  btn_type            btn,
   input  logic [3:0]         initial_delay,
   input  logic [6:0]         coarse_step,
   input  logic [ID_BITS-1:0] tracked_cur,
   input  rep_state_type      rep_cur,
   output logic [ID_BITS-1:0] tracked_nxt,
   output rep_state_type      rep_nxt,
   output logic signed [7:0]  step
);

   logic       active;
   logic       neg;
   logic       pos;
   logic       steering;
   logic       shoulder;
   logic       same_item;
   logic [3:0] dirs;
   logic [1:0] stage;
   logic [6:0] units;

   assign dirs     = {btn.rshoulder, btn.lshoulder, btn.right, btn.left};
   assign neg      = dirs[DIR_LEFT] | dirs[DIR_LSH];
   assign pos      = dirs[DIR_RIGHT] | dirs[DIR_RSH];
   assign shoulder = dirs[DIR_LSH] | dirs[DIR_RSH];
   assign steering = btn.confirm & (neg ^ pos);
   assign active   = (id != '0) & focused & ~text_entry_active;
   assign same_item = (tracked_cur == id);
   assign stage    = stage_of(rep_cur.repeat_count);

   always_comb begin
      tracked_nxt = tracked_cur;
      rep_nxt     = rep_cur;
      units       = 7'd0;
      if (active) begin
         if (!steering) begin
            // release: forget the press, keep the pending delay
            if (same_item) begin
               tracked_nxt          = '0;
               rep_nxt.dirs         = 4'd0;
               rep_nxt.repeat_count = 8'd0;
            end
         end else if (same_item && (rep_cur.dirs == dirs)) begin
            if (rep_cur.delay_left > 4'd1) begin
               rep_nxt.delay_left = rep_cur.delay_left - 4'd1;
            end else begin
               rep_nxt.delay_left = STAGE_INTERVAL[stage];
               units = shoulder ? coarse_step : STAGE_MULT[stage];
               if (rep_cur.repeat_count != REPEAT_MAX) begin
                  rep_nxt.repeat_count = rep_cur.repeat_count + 8'd1;
               end
            end
         end else begin
            // new press
            tracked_nxt          = id;
            rep_nxt.dirs         = dirs;
            rep_nxt.delay_left   = initial_delay;
            rep_nxt.repeat_count = 8'd0;
            units = shoulder ? coarse_step : 7'd1;
         end
      end
   end

   assign step = pos ? $signed({1'b0, units}) : -$signed({1'b0, units});

endmodule

[design/slider_autorepeat_stepper.sv]
// ----------------------------------------------------------------------------
// slider_autorepeat_stepper
// Accelerating autorepeat stepper for an integer slider, one item per tick.
// ----------------------------------------------------------------------------
// Path: rsp_valid rises once an item has passed the input register, then
//   the result register.
// Throughput: one item per cycle while the result register is empty or
//   drained; the tracker state updates as each item leaves the input register.
// Reset: synchronous, active high; clears both valid flags and the tracker,
//   loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module slider_autorepeat_stepper
   import slas_pkg::*;
#(
   parameter int ID_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_item_id,
   input  logic                  req_focused,
   input  logic                  req_text_entry_active,
   input  logic                  req_held_confirm,
   input  logic                  req_held_left,
   input  logic                  req_held_right,
   input  logic                  req_held_lshoulder,
   input  logic                  req_held_rshoulder,
   input  logic signed [31:0]    req_value,
   input  logic signed [31:0]    req_min_value,
   input  logic signed [31:0]    req_max_value,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [7:0]     rsp_step,
   output logic signed [31:0]    rsp_new_value,
   output logic                  rsp_changed
);

   // Configuration registers
   logic [3:0] initial_delay_ff;
   logic [6:0] coarse_step_ff;

   // Input register
   logic               in_valid_ff;
   logic [31:0]        item_id_ff;
   logic               focused_ff;
   logic               text_entry_ff;
   btn_type            btn_ff;
   logic signed [31:0] value_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] max_ff;

   // Tracker state
   logic [ID_BITS-1:0] tracked_ff;
   logic [ID_BITS-1:0] tracked_in;
   rep_state_type      rep_ff;
   rep_state_type      rep_in;

   // Result register
   logic               rsp_valid_ff;
   logic signed [7:0]  step_ff;
   logic signed [31:0] new_value_ff;
   logic               changed_ff;

   logic               advance;
   logic               fire;
   logic signed [7:0]  step_in;
   logic signed [32:0] sum;
   logic signed [32:0] lo_clamped;
   logic signed [32:0] hi_clamped;
   logic signed [31:0] new_value_in;

   // The result register is empty or drains this cycle: move the item on.
   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign fire      = in_valid_ff & advance;
   assign req_ready = ~in_valid_ff | advance;
   assign csr_ready = 1'b1;

   slas_repeat_ctrl #(
      .ID_BITS (ID_BITS)
   ) u_repeat (
      .id                (ID_BITS'(item_id_ff)),
      .focused           (focused_ff),
      .text_entry_active (text_entry_ff),
      .btn               (btn_ff),
      .initial_delay     (initial_delay_ff),
      .coarse_step       (coarse_step_ff),
      .tracked_cur       (tracked_ff),
      .rep_cur           (rep_ff),
      .tracked_nxt       (tracked_in),
      .rep_nxt           (rep_in),
      .step              (step_in)
   );

   // Add the step, then apply the lower clamp before the upper one, so that
   // inverted limits settle on max_value whenever clamping happens.
   always_comb begin
      sum        = 33'(value_ff) + 33'(step_in);
      lo_clamped = (sum < 33'(min_ff)) ? 33'(min_ff) : sum;
      hi_clamped = (lo_clamped > 33'(max_ff)) ? 33'(max_ff) : lo_clamped;
      if (step_in != 8'sd0) begin
         new_value_in = hi_clamped[31:0];
      end else begin
         new_value_in = value_ff;
      end
   end

   // Control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         tracked_ff       <= '0;
         rep_ff           <= '0;
         initial_delay_ff <= RESET_INITIAL_DELAY;
         coarse_step_ff   <= RESET_COARSE_STEP;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            tracked_ff <= tracked_in;
            rep_ff     <= rep_in;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_INITIAL_DELAY: initial_delay_ff <= csr_wdata[3:0];
               CSR_COARSE_STEP:   coarse_step_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   // Payload: capture inputs on the request transfer and results as an item leaves, hold while stalled
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_id_ff    <= req_item_id;
         focused_ff    <= req_focused;
         text_entry_ff <= req_text_entry_active;
         btn_ff        <= '{confirm:   req_held_confirm,
                            left:      req_held_left,
                            right:     req_held_right,
                            lshoulder: req_held_lshoulder,
                            rshoulder: req_held_rshoulder};
         value_ff      <= req_value;
         min_ff        <= req_min_value;
         max_ff        <= req_max_value;
      end
      if (fire) begin
         step_ff      <= step_in;
         new_value_ff <= new_value_in;
         changed_ff   <= (new_value_in != value_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_step      = step_ff;
   assign rsp_new_value = new_value_ff;
   assign rsp_changed   = changed_ff;

   // A change in value always comes from a nonzero step.
   a_change_needs_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && changed_ff |-> step_ff != 8'sd0)
      else $error("value changed with zero step");

   // No tracked item exactly when no direction set is tracked.
   a_tracker_consistent: assert property (@(posedge clock) disable iff (reset)
      (tracked_ff == '0) == (rep_ff.dirs == 4'd0))
      else $error("tracker item and direction set disagree");

   // The tracker moves only when an item leaves the input register.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(tracked_ff) && $stable(rep_ff))
      else $error("tracker changed without an item");

   // The repeat count saturates rather than wrapping past its maximum.
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      rep_ff.repeat_count == REPEAT_MAX |=>
         rep_ff.repeat_count == REPEAT_MAX || rep_ff.repeat_count == 8'd0)
      else $error("repeat count wrapped");

endmodule
